@@ hdl/ultrasonic_tof_pulse_matcher_defines.svh @@
// Assertion macros shared by the checker of the ultrasonic time-of-flight pulse matcher.
// Depends on nothing; the checker takes it in by include.
`ifndef ULTRASONIC_TOF_PULSE_MATCHER_DEFINES_SVH
`define ULTRASONIC_TOF_PULSE_MATCHER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define UTPM_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utpm: same-cycle check failed");

// Next-cycle implication, disabled while reset is held.
`define UTPM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utpm: next-cycle check failed");

`endif

@@ hdl/utpm_pkg.sv @@
// Package of the ultrasonic time-of-flight pulse matcher: widths, opcodes and state type.
// Used by the channel interfaces, the top level and the checker.
`default_nettype none

package utpm_pkg;

    localparam int MAX_STOPS = 16;

    localparam int OP_W      = 2;
    localparam int TS_W      = 32;
    localparam int PERIOD_W  = 16;
    localparam int SUM_W     = 38;
    localparam int FRAC_W    = 8;
    localparam int TOF_W     = 40;
    localparam int PULSE_W   = 5;
    localparam int TGT_W     = TS_W + 1;
    localparam int DIV_W     = SUM_W + FRAC_W;
    localparam int DIV_CNT_W = $clog2(DIV_W);
    localparam int PULSE_SAT = 31;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd6000;

    localparam logic [OP_W-1:0] OP_START  = 2'd0;
    localparam logic [OP_W-1:0] OP_STOP   = 2'd1;
    localparam logic [OP_W-1:0] OP_FINISH = 2'd2;

    localparam logic [TOF_W-1:0] TOF_MAX = {1'b0, {(TOF_W-1){1'b1}}};
    localparam logic [TOF_W-1:0] TOF_MIN = {1'b1, {(TOF_W-1){1'b0}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DELAY,
        ST_SEARCH,
        ST_ACCUM,
        ST_DIV_LOAD,
        ST_DIV,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

@@ hdl/utpm_if.sv @@
// Valid/ready channel interfaces of the pulse matcher: timestamp items, results, configuration.
// Depends on utpm_pkg for field widths.
`default_nettype none

interface utpm_in_if;
    logic                           valid;
    logic                           ready;
    logic [utpm_pkg::OP_W-1:0]      opcode;
    logic [utpm_pkg::TS_W-1:0]      timestamp;

    modport source (output valid, opcode, timestamp, input ready);
    modport sink   (input valid, opcode, timestamp, output ready);
endinterface

interface utpm_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [utpm_pkg::TOF_W-1:0]  tof_value;
    logic [utpm_pkg::PULSE_W-1:0]       pulse_total;
    logic                               no_pulses;

    modport source (output valid, tof_value, pulse_total, no_pulses, input ready);
    modport sink   (input valid, tof_value, pulse_total, no_pulses, output ready);
endinterface

interface utpm_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [utpm_pkg::PERIOD_W-1:0]      data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

@@ hdl/ultrasonic_tof_pulse_matcher.sv @@
// Ultrasonic time-of-flight pulse matcher: top level with sequencer and shared subtractor.
// Depends on utpm_pkg and the channel interfaces in utpm_if.sv.
//
// The block takes bursts of 32-bit counter timestamps. A start item records the reference
// time. Each stop item, up to MAX_STOPS per burst, gives a delay |stop - start|, which is
// matched to the nearest echo slot first_delay + k*period (lowest k on a tie) and the
// corrected delay delay - k*period is added to a 38-bit wrapping sum. A finish item emits
// the rounded mean of the corrected delays in cycles with 8 fraction bits, saturated to
// 40 bits, plus the pulse count and a flag for an empty burst, then clears the burst
// (the start time is kept). A small sequencer shares one subtractor among the delay, the
// slot error, the negated sum and the divider, so the block takes one item at a time: a
// start item, an opcode 3 item and a stop after the burst is full are handled in the idle
// state, and a finish of an empty burst goes straight to emit. A stop goes through the
// delay, search and accumulate states, the search trying one slot per cycle; a nonempty
// finish goes through the load, divide and emit states, the restoring divider making one
// quotient bit per cycle over 46 bits. Any finish also waits for the result register to
// be freed. The result sits in an output register, so new start and stop items are taken
// while a result still waits. The period register is written through the configuration
// channel, which is always ready, and must only be written while the block is idle.
`default_nettype none

module ultrasonic_tof_pulse_matcher #(
    parameter int MAX_STOPS = utpm_pkg::MAX_STOPS
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    utpm_cfg_if.sink        i_cfg,
    utpm_in_if.sink         i_in,
    utpm_out_if.source      o_out
);

    // Stop counter holds 0..MAX_STOPS; slot index runs 0..MAX_STOPS-1.
    localparam int CNT_W  = $clog2(MAX_STOPS + 1);
    localparam int K_W    = (MAX_STOPS > 1) ? $clog2(MAX_STOPS) : 1;
    localparam int KOFF_W = utpm_pkg::PERIOD_W + K_W;
    localparam int TGT_W  = utpm_pkg::TGT_W;
    localparam int ALU_W  = utpm_pkg::DIV_W;
    localparam int TS_W   = utpm_pkg::TS_W;
    localparam int SUM_W  = utpm_pkg::SUM_W;
    localparam int TOF_W  = utpm_pkg::TOF_W;
    localparam int PUL_W  = utpm_pkg::PULSE_W;
    localparam int DCNT_W = utpm_pkg::DIV_CNT_W;
    localparam int PW     = (CNT_W > PUL_W) ? CNT_W : PUL_W;

    // Sequencer state.
    utpm_pkg::t_state r_state, n_state;

    // Configuration and burst state.
    logic [utpm_pkg::PERIOD_W-1:0] r_period;
    logic [TS_W-1:0]               r_start, n_start;
    logic [TS_W-1:0]               r_first, n_first;
    logic [SUM_W-1:0]              r_sum,   n_sum;
    logic [CNT_W-1:0]              r_count, n_count;

    // Working registers of the stop search.
    logic [TS_W-1:0]               r_ts,        n_ts;
    logic [TS_W-1:0]               r_delay,     n_delay;
    logic [TGT_W-1:0]              r_target,    n_target;
    logic [KOFF_W-1:0]             r_koff,      n_koff;
    logic [K_W-1:0]                r_k,         n_k;
    logic [TGT_W-1:0]              r_best_err,  n_best_err;
    logic [KOFF_W-1:0]             r_best_koff, n_best_koff;

    // Working registers of the divider.
    logic [ALU_W-1:0]              r_quo, n_quo;
    logic [CNT_W-1:0]              r_rem, n_rem;
    logic [DCNT_W-1:0]             r_bit, n_bit;
    logic                          r_neg, n_neg;

    // Result register.
    logic                          r_out_valid, n_out_valid;
    logic [TOF_W-1:0]              r_tof,       n_tof;
    logic [PUL_W-1:0]              r_pulse,     n_pulse;
    logic                          r_nop,       n_nop;

    // Shared subtractor.
    logic [ALU_W-1:0]              w_alu_a, w_alu_b;
    logic [ALU_W:0]                w_alu_diff, w_alu_abs;
    logic                          w_alu_borrow;

    logic                          w_in_acc, w_emit_go, w_full, w_last_k;
    logic [ALU_W-1:0]              w_num, w_mag, w_dividend;
    logic [CNT_W:0]                w_rem_shift;
    logic [TS_W-1:0]               w_delay_now, w_first_now;
    logic [TGT_W-1:0]              w_err;
    logic [SUM_W-1:0]              w_corr;
    logic [TOF_W-1:0]              w_tof_sat;
    logic [PW-1:0]                 w_cnt_wide;
    logic [PUL_W-1:0]              w_pulse;

    assign i_in.ready  = (r_state == utpm_pkg::ST_IDLE);
    assign i_cfg.ready = 1'b1;

    assign o_out.valid       = r_out_valid;
    assign o_out.tof_value   = r_tof;
    assign o_out.pulse_total = r_pulse;
    assign o_out.no_pulses   = r_nop;

    assign w_in_acc  = i_in.valid & i_in.ready;
    assign w_emit_go = !r_out_valid | o_out.ready;
    assign w_full    = (r_count >= CNT_W'(MAX_STOPS));
    assign w_last_k  = (r_k == K_W'(MAX_STOPS - 1));

    // The sum scaled by 256; its sign is the sum's sign bit.
    assign w_num       = {r_sum, {utpm_pkg::FRAC_W{1'b0}}};
    assign w_rem_shift = {r_rem, r_quo[ALU_W-1]};

    // Operand selection for the one subtractor: delay, slot error, negation of the
    // scaled sum, and the divider's trial subtraction all use it in turn.
    always_comb begin
        w_alu_a = '0;
        w_alu_b = '0;
        case (r_state)
            utpm_pkg::ST_DELAY: begin
                w_alu_a = ALU_W'(r_ts);
                w_alu_b = ALU_W'(r_start);
            end
            utpm_pkg::ST_SEARCH: begin
                w_alu_a = ALU_W'(r_target);
                w_alu_b = ALU_W'(r_delay);
            end
            utpm_pkg::ST_DIV_LOAD: begin
                w_alu_b = w_num;
            end
            utpm_pkg::ST_DIV: begin
                w_alu_a = ALU_W'(w_rem_shift);
                w_alu_b = ALU_W'(r_count);
            end
            default: begin
            end
        endcase
    end

    assign w_alu_diff   = {1'b0, w_alu_a} - {1'b0, w_alu_b};
    assign w_alu_borrow = w_alu_diff[ALU_W];
    assign w_alu_abs    = w_alu_borrow ? ((ALU_W+1)'(0) - w_alu_diff) : w_alu_diff;

    assign w_delay_now = w_alu_abs[TS_W-1:0];
    assign w_first_now = (r_count == '0) ? w_delay_now : r_first;
    assign w_err       = w_alu_abs[TGT_W-1:0];
    assign w_corr      = SUM_W'(r_delay) - SUM_W'(r_best_koff);

    // Magnitude of the scaled sum plus half the count gives round-half-away-from-zero.
    assign w_mag      = r_sum[SUM_W-1] ? w_alu_diff[ALU_W-1:0] : w_num;
    assign w_dividend = w_mag + ALU_W'(r_count >> 1);

    // Sign and saturation of the quotient into the 40-bit result.
    always_comb begin
        if (r_count == '0) begin
            w_tof_sat = '0;
        end else if (!r_neg) begin
            if (|r_quo[ALU_W-1:TOF_W-1]) begin
                w_tof_sat = utpm_pkg::TOF_MAX;
            end else begin
                w_tof_sat = r_quo[TOF_W-1:0];
            end
        end else begin
            if ((|r_quo[ALU_W-1:TOF_W]) || (r_quo[TOF_W-1] && (|r_quo[TOF_W-2:0]))) begin
                w_tof_sat = utpm_pkg::TOF_MIN;
            end else begin
                w_tof_sat = TOF_W'(0) - r_quo[TOF_W-1:0];
            end
        end
    end

    assign w_cnt_wide = PW'(r_count);
    assign w_pulse    = (w_cnt_wide > PW'(utpm_pkg::PULSE_SAT)) ?
                        PUL_W'(utpm_pkg::PULSE_SAT) : w_cnt_wide[PUL_W-1:0];

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            utpm_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    case (i_in.opcode)
                        utpm_pkg::OP_STOP: begin
                            if (!w_full) begin
                                n_state = utpm_pkg::ST_DELAY;
                            end
                        end
                        utpm_pkg::OP_FINISH: begin
                            n_state = (r_count == '0) ? utpm_pkg::ST_EMIT
                                                      : utpm_pkg::ST_DIV_LOAD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            utpm_pkg::ST_DELAY:    n_state = utpm_pkg::ST_SEARCH;
            utpm_pkg::ST_SEARCH: begin
                if (w_last_k) begin
                    n_state = utpm_pkg::ST_ACCUM;
                end
            end
            utpm_pkg::ST_ACCUM:    n_state = utpm_pkg::ST_IDLE;
            utpm_pkg::ST_DIV_LOAD: n_state = utpm_pkg::ST_DIV;
            utpm_pkg::ST_DIV: begin
                if (r_bit == '0) begin
                    n_state = utpm_pkg::ST_EMIT;
                end
            end
            utpm_pkg::ST_EMIT: begin
                if (w_emit_go) begin
                    n_state = utpm_pkg::ST_IDLE;
                end
            end
            default:               n_state = utpm_pkg::ST_IDLE;
        endcase
    end

    // Datapath next values.
    always_comb begin
        n_start     = r_start;
        n_first     = r_first;
        n_sum       = r_sum;
        n_count     = r_count;
        n_ts        = r_ts;
        n_delay     = r_delay;
        n_target    = r_target;
        n_koff      = r_koff;
        n_k         = r_k;
        n_best_err  = r_best_err;
        n_best_koff = r_best_koff;
        n_quo       = r_quo;
        n_rem       = r_rem;
        n_bit       = r_bit;
        n_neg       = r_neg;
        n_tof       = r_tof;
        n_pulse     = r_pulse;
        n_nop       = r_nop;
        n_out_valid = r_out_valid & !o_out.ready;
        case (r_state)
            utpm_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    case (i_in.opcode)
                        utpm_pkg::OP_START: begin
                            n_start = i_in.timestamp;
                            n_first = '0;
                            n_sum   = '0;
                            n_count = '0;
                        end
                        utpm_pkg::OP_STOP: begin
                            n_ts = i_in.timestamp;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            utpm_pkg::ST_DELAY: begin
                n_delay  = w_delay_now;
                n_first  = w_first_now;
                n_target = TGT_W'(w_first_now);
                n_koff   = '0;
                n_k      = '0;
            end
            utpm_pkg::ST_SEARCH: begin
                // Strictly smaller error wins, so the lowest slot keeps a tie.
                if ((r_k == '0) || (w_err < r_best_err)) begin
                    n_best_err  = w_err;
                    n_best_koff = r_koff;
                end
                n_k      = r_k + 1'b1;
                n_target = r_target + TGT_W'(r_period);
                n_koff   = r_koff + KOFF_W'(r_period);
            end
            utpm_pkg::ST_ACCUM: begin
                n_sum   = r_sum + w_corr;
                n_count = r_count + 1'b1;
            end
            utpm_pkg::ST_DIV_LOAD: begin
                n_quo = w_dividend;
                n_rem = '0;
                n_bit = DCNT_W'(ALU_W - 1);
                n_neg = r_sum[SUM_W-1];
            end
            utpm_pkg::ST_DIV: begin
                n_rem = w_alu_borrow ? w_rem_shift[CNT_W-1:0] : w_alu_diff[CNT_W-1:0];
                n_quo = {r_quo[ALU_W-2:0], !w_alu_borrow};
                n_bit = r_bit - 1'b1;
            end
            utpm_pkg::ST_EMIT: begin
                if (w_emit_go) begin
                    n_tof       = w_tof_sat;
                    n_pulse     = w_pulse;
                    n_nop       = (r_count == '0);
                    n_out_valid = 1'b1;
                    n_first     = '0;
                    n_sum       = '0;
                    n_count     = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= utpm_pkg::ST_IDLE;
            r_period    <= utpm_pkg::PERIOD_RESET;
            r_start     <= '0;
            r_first     <= '0;
            r_sum       <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_start     <= n_start;
            r_first     <= n_first;
            r_sum       <= n_sum;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
            if (i_cfg.valid && i_cfg.ready) begin
                r_period <= i_cfg.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ts        <= n_ts;
        r_delay     <= n_delay;
        r_target    <= n_target;
        r_koff      <= n_koff;
        r_k         <= n_k;
        r_best_err  <= n_best_err;
        r_best_koff <= n_best_koff;
        r_quo       <= n_quo;
        r_rem       <= n_rem;
        r_bit       <= n_bit;
        r_neg       <= n_neg;
        r_tof       <= n_tof;
        r_pulse     <= n_pulse;
        r_nop       <= n_nop;
    end

endmodule

`default_nettype wire

@@ hdl/utpm_checker.sv @@
// Port-level checker of the pulse matcher and the bind that attaches it to the top level.
// Depends on utpm_pkg and the assertion macros in ultrasonic_tof_pulse_matcher_defines.svh.
`default_nettype none
`include "ultrasonic_tof_pulse_matcher_defines.svh"

module utpm_checker (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            i_in_valid,
    input wire logic                            i_in_ready,
    input wire logic [utpm_pkg::OP_W-1:0]       i_in_opcode,
    input wire logic                            i_out_valid,
    input wire logic                            i_out_ready,
    input wire logic [utpm_pkg::TOF_W-1:0]      i_tof,
    input wire logic [utpm_pkg::PULSE_W-1:0]    i_pulse,
    input wire logic                            i_nop
);

    logic w_empty;
    logic w_fin_acc;
    logic w_stall;

    assign w_empty   = i_out_valid && i_nop;
    assign w_fin_acc = i_in_valid && i_in_ready && (i_in_opcode == utpm_pkg::OP_FINISH);
    assign w_stall   = i_out_valid && !i_out_ready;

    // An empty burst reports a zero mean and a zero count.
    `UTPM_ASSERT_IMPLY(a_empty_zero, i_clk, i_rst_n, w_empty, i_tof == '0 && i_pulse == '0)

    // A burst with pulses reports a nonzero count.
    `UTPM_ASSERT_IMPLY(a_count_flag, i_clk, i_rst_n, i_out_valid && !i_nop, i_pulse != '0)

    // A finish item always occupies the sequencer for at least the next cycle.
    `UTPM_ASSERT_NEXT(a_finish_busy, i_clk, i_rst_n, w_fin_acc, !i_in_ready)

    // A result that is not taken stays put.
    `UTPM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_stall, i_out_valid && $stable({i_tof, i_pulse}))

endmodule

bind ultrasonic_tof_pulse_matcher utpm_checker u_utpm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_opcode (i_in.opcode),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_tof       (o_out.tof_value),
    .i_pulse     (o_out.pulse_total),
    .i_nop       (o_out.no_pulses)
);

`default_nettype wire
